FILE: design/hpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the H-bridge position compensator.
// No dependencies; every other design file refers to this package by scoped names.
package hpc_pkg;

	localparam int SAMPLE_WIDTH    = 12;
	localparam int REF_WIDTH       = 12;
	localparam int COEF_WIDTH      = 16;
	localparam int DUTY_WIDTH      = 9;
	localparam int ERR_WIDTH       = 11;
	localparam int ERR_FULL_WIDTH  = ((REF_WIDTH > SAMPLE_WIDTH) ? REF_WIDTH : SAMPLE_WIDTH) + 1;
	localparam int STATE_WIDTH_DEF = 32;
	localparam int CFG_INDEX_WIDTH = 3;

	localparam int Q_FRAC    = 12;
	localparam int IN_SHIFT  = 4;
	localparam int OUT_SHIFT = 8;

	localparam int WIN_HIGH    = 950;
	localparam int WIN_LOW     = -700;
	localparam int DRIVE_LIMIT = 408;
	localparam int RAMP_START  = 500;
	localparam int REF_RESET   = 1524;
	localparam int ONE_Q12     = 4096;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_REFERENCE     = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_IN       = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_CUR_IN   = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_PREV_IN  = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_PREV_OUT = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_OUT      = 3'd5;

	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_FWD  = 2'b01;
	localparam logic [1:0] DIR_REV  = 2'b10;

	typedef struct packed {
		logic [SAMPLE_WIDTH-1:0] adc_sample;
		logic                    digital_mode;
		logic                    motor_off;
	} in_item_t;

	typedef struct packed {
		logic [DUTY_WIDTH-1:0] duty;
		logic                  drive_fwd;
		logic                  drive_rev;
		logic                  fault;
	} out_item_t;

	typedef struct packed {
		logic signed [COEF_WIDTH-1:0] gain_in;
		logic signed [COEF_WIDTH-1:0] coef_cur_in;
		logic signed [COEF_WIDTH-1:0] coef_prev_in;
		logic signed [COEF_WIDTH-1:0] coef_prev_out;
		logic signed [COEF_WIDTH-1:0] gain_out;
	} coef_set_t;

	typedef struct packed {
		logic                  done;
		logic [DUTY_WIDTH-1:0] duty;
		logic                  rev;
	} filt_res_t;

endpackage

FILE: design/hpc_booth_mul.sv
`timescale 1ns / 1ps
// Digit-serial signed multiplier, radix-4 Booth, two coefficient bits per cycle.
// Depends on hpc_pkg for the coefficient width and the default operand width.
module hpc_booth_mul #(
	parameter int A_WIDTH = hpc_pkg::STATE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [A_WIDTH-1:0]         a,
	input  logic signed [hpc_pkg::COEF_WIDTH-1:0] c,
	output logic [A_WIDTH+hpc_pkg::COEF_WIDTH-1:0] product,
	output logic                              done
);

	localparam int CW        = hpc_pkg::COEF_WIDTH;
	localparam int PW        = A_WIDTH + CW;
	localparam int STEPS     = CW / 2;
	localparam int STEP_BITS = $clog2(STEPS);

	logic [PW-1:0]        mcand_q;
	logic [CW:0]          coef_q;
	logic [PW-1:0]        acc_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 busy_q;
	logic                 done_q;
	logic [PW-1:0]        pp;

	always_comb begin
		unique case (coef_q[2:0])
			3'b000, 3'b111: pp = '0;
			3'b001, 3'b010: pp = mcand_q;
			3'b011:         pp = mcand_q << 1;
			3'b100:         pp = PW'(-(mcand_q << 1));
			3'b101, 3'b110: pp = PW'(-mcand_q);
			default:        pp = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_BITS'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= '0;
			mcand_q <= {{CW{a[A_WIDTH-1]}}, a};
			coef_q  <= {c, 1'b0};
		end else if (busy_q) begin
			acc_q   <= acc_q + pp;
			mcand_q <= mcand_q << 2;
			coef_q  <= {{2{coef_q[CW]}}, coef_q[CW:2]};
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule

FILE: design/hpc_filter.sv
`timescale 1ns / 1ps
// Digital compensation path: input gain, first-order IIR section, output gain and clamp.
// Depends on hpc_pkg and sequences the five products through one hpc_booth_mul.
module hpc_filter #(
	parameter int STATE_WIDTH = hpc_pkg::STATE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [hpc_pkg::ERR_WIDTH-1:0] err,
	input  hpc_pkg::coef_set_t                  coefs,
	output hpc_pkg::filt_res_t                  res
);

	localparam int SW   = STATE_WIDTH;
	localparam int CW   = hpc_pkg::COEF_WIDTH;
	localparam int EW   = hpc_pkg::ERR_WIDTH;
	localparam int DW   = hpc_pkg::DUTY_WIDTH;
	localparam int QF   = hpc_pkg::Q_FRAC;
	localparam int QI   = hpc_pkg::IN_SHIFT;
	localparam int QO   = hpc_pkg::OUT_SHIFT;
	localparam int PW   = SW + CW;
	localparam int TW   = PW - QF;
	localparam int S4W  = PW - QI;
	localparam int SUMW = TW + 2;

	localparam logic [PW-1:0] RND_Q  = PW'((1 << QF) - 1);
	localparam logic [PW-1:0] RND_IN = PW'((1 << QI) - 1);
	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [TW-1:0] LIM_POS = TW'(hpc_pkg::DRIVE_LIMIT * 256);
	localparam logic signed [TW-1:0] LIM_NEG = TW'(-(hpc_pkg::DRIVE_LIMIT * 256));

	localparam logic [2:0] F_IDLE     = 3'd0;
	localparam logic [2:0] F_GAIN_IN  = 3'd1;
	localparam logic [2:0] F_CUR      = 3'd2;
	localparam logic [2:0] F_PREV_IN  = 3'd3;
	localparam logic [2:0] F_PREV_OUT = 3'd4;
	localparam logic [2:0] F_GAIN_OUT = 3'd5;
	localparam logic [2:0] F_CLAMP    = 3'd6;

	logic [2:0]              st_q;
	logic                    mul_start_q;
	logic signed [SW-1:0]    mul_a;
	logic signed [CW-1:0]    mul_c;
	logic [PW-1:0]           mul_p;
	logic                    mul_done;

	logic [PW-1:0]           p_rq;
	logic [PW-1:0]           p_ri;
	logic signed [TW-1:0]    term;
	logic signed [SUMW-1:0]  term_x;
	logic signed [SUMW-1:0]  sum_next;
	logic signed [S4W-1:0]   scaled_full;
	logic [S4W-SW:0]         s_hi;
	logic [SUMW-SW:0]        f_hi;
	logic signed [SW-1:0]    s_sat;
	logic signed [SW-1:0]    f_sat;

	logic signed [SW-1:0]    s_q;
	logic signed [SW-1:0]    f_q;
	logic signed [SW-1:0]    psi_q;
	logic signed [SW-1:0]    pfo_q;
	logic signed [SUMW-1:0]  sum_q;
	logic signed [TW-1:0]    o_q;
	logic [DW-1:0]           duty_q;
	logic                    rev_q;
	logic                    done_q;

	logic                    over;
	logic                    under;
	logic [TW-1:0]           mag;
	logic [DW-1:0]           duty_c;

	hpc_booth_mul #(
		.A_WIDTH(SW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a),
		.c      (mul_c),
		.product(mul_p),
		.done   (mul_done)
	);

	always_comb begin
		unique case (st_q)
			F_GAIN_IN: begin
				mul_a = {{(SW-EW){err[EW-1]}}, err};
				mul_c = coefs.gain_in;
			end
			F_CUR: begin
				mul_a = s_q;
				mul_c = coefs.coef_cur_in;
			end
			F_PREV_IN: begin
				mul_a = psi_q;
				mul_c = coefs.coef_prev_in;
			end
			F_PREV_OUT: begin
				mul_a = pfo_q;
				mul_c = coefs.coef_prev_out;
			end
			F_GAIN_OUT: begin
				mul_a = f_q;
				mul_c = coefs.gain_out;
			end
			default: begin
				mul_a = '0;
				mul_c = '0;
			end
		endcase
	end

	// Products are truncated toward zero: negative values are biased before the shift.
	always_comb begin
		p_rq        = mul_p + (mul_p[PW-1] ? RND_Q : '0);
		p_ri        = mul_p + (mul_p[PW-1] ? RND_IN : '0);
		term        = p_rq[PW-1:QF];
		term_x      = {{2{term[TW-1]}}, term};
		sum_next    = sum_q + term_x;
		scaled_full = p_ri[PW-1:QI];
		s_hi        = scaled_full[S4W-1:SW-1];
		f_hi        = sum_next[SUMW-1:SW-1];
		if (s_hi == '0 || s_hi == '1) begin
			s_sat = scaled_full[SW-1:0];
		end else begin
			s_sat = scaled_full[S4W-1] ? S_MIN : S_MAX;
		end
		if (f_hi == '0 || f_hi == '1) begin
			f_sat = sum_next[SW-1:0];
		end else begin
			f_sat = sum_next[SUMW-1] ? S_MIN : S_MAX;
		end
	end

	always_comb begin
		over  = o_q > LIM_POS;
		under = o_q < LIM_NEG;
		mag   = o_q[TW-1] ? TW'(-o_q) : o_q;
		if (over || under) begin
			duty_c = DW'(hpc_pkg::DRIVE_LIMIT);
		end else begin
			duty_c = mag[QO+DW-1:QO];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= F_IDLE;
			mul_start_q <= 1'b0;
			done_q      <= 1'b0;
			psi_q       <= '0;
			pfo_q       <= '0;
		end else begin
			mul_start_q <= 1'b0;
			done_q      <= 1'b0;
			unique case (st_q)
				F_IDLE: begin
					if (start) begin
						st_q        <= F_GAIN_IN;
						mul_start_q <= 1'b1;
					end
				end
				F_GAIN_IN: begin
					if (mul_done) begin
						st_q        <= F_CUR;
						mul_start_q <= 1'b1;
					end
				end
				F_CUR: begin
					if (mul_done) begin
						st_q        <= F_PREV_IN;
						mul_start_q <= 1'b1;
					end
				end
				F_PREV_IN: begin
					if (mul_done) begin
						st_q        <= F_PREV_OUT;
						mul_start_q <= 1'b1;
					end
				end
				F_PREV_OUT: begin
					if (mul_done) begin
						st_q        <= F_GAIN_OUT;
						mul_start_q <= 1'b1;
					end
				end
				F_GAIN_OUT: begin
					if (mul_done) begin
						st_q  <= F_CLAMP;
						psi_q <= s_q;
						pfo_q <= f_q;
					end
				end
				F_CLAMP: begin
					st_q   <= F_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_done) begin
			unique case (st_q)
				F_GAIN_IN:  s_q   <= s_sat;
				F_CUR:      sum_q <= term_x;
				F_PREV_IN:  sum_q <= sum_q - term_x;
				F_PREV_OUT: f_q   <= f_sat;
				F_GAIN_OUT: o_q   <= term;
				default: ;
			endcase
		end
		if (st_q == F_CLAMP) begin
			duty_q <= duty_c;
			rev_q  <= o_q[TW-1];
		end
	end

	assign res = '{done: done_q, duty: duty_q, rev: rev_q};

endmodule

FILE: design/hbridge_position_compensator_core.sv
`timescale 1ns / 1ps
// Top level of the H-bridge position compensator: channels, registers, window and ramp.
// Depends on hpc_pkg and instantiates hpc_filter.
//
//   Channel  Signals                          Direction  Payload
//   in       in_valid, in_stall, in_item      input      hpc_pkg::in_item_t
//   out      out_valid, out_stall, out_item   output     hpc_pkg::out_item_t
//   cfg      cfg_we, cfg_index, cfg_data      input      register write, no read-back
//
// In digital mode an item's time is set by the five eight-step radix-4 products of the
// shared serial multiplier; fault and direct mode skip the filter. One item is in work
// at a time; in_stall is high until its result is in the output register. A stalled
// output holds the block in its last step, and a held result never blocks the
// acceptance of the next item. Reset is asynchronous.
module hbridge_position_compensator_core #(
	parameter int STATE_WIDTH = hpc_pkg::STATE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  hpc_pkg::in_item_t                     in_item,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output hpc_pkg::out_item_t                    out_item,
	input  logic                                  cfg_we,
	input  logic [hpc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [hpc_pkg::COEF_WIDTH-1:0]        cfg_data
);

	localparam int EW = hpc_pkg::ERR_FULL_WIDTH;
	localparam int DW = hpc_pkg::DUTY_WIDTH;
	localparam int RW = hpc_pkg::REF_WIDTH;
	localparam int XW = hpc_pkg::ERR_WIDTH;

	localparam logic signed [EW-1:0] WIN_HI  = EW'(hpc_pkg::WIN_HIGH);
	localparam logic signed [EW-1:0] WIN_LO  = EW'(hpc_pkg::WIN_LOW);
	localparam logic signed [EW-1:0] LIM_HI  = EW'(hpc_pkg::DRIVE_LIMIT);
	localparam logic signed [EW-1:0] LIM_LO  = EW'(-hpc_pkg::DRIVE_LIMIT);
	localparam logic [DW-1:0]        DUTY_LIM = DW'(hpc_pkg::DRIVE_LIMIT);

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_EVAL = 2'd1;
	localparam logic [1:0] T_FILT = 2'd2;
	localparam logic [1:0] T_OUT  = 2'd3;

	logic [1:0]                st_q;
	logic                      out_valid_q;
	logic [1:0]                dir_q;
	logic [DW-1:0]             ramp_q;
	logic [RW-1:0]             ref_q;
	hpc_pkg::coef_set_t        coefs_q;

	hpc_pkg::in_item_t         item_q;
	logic [DW-1:0]             duty_q;
	logic [1:0]                res_dir_q;
	logic                      res_fault_q;
	hpc_pkg::out_item_t        out_item_q;

	logic signed [EW-1:0]      err;
	logic signed [EW-1:0]      err_neg;
	logic                      in_win;
	logic                      filt_start;
	logic [DW-1:0]             direct_duty;
	logic [1:0]                direct_dir;
	logic                      out_free;
	logic [DW-1:0]             final_duty;
	logic [1:0]                final_dir;
	hpc_pkg::filt_res_t        filt_res;

	hpc_filter #(
		.STATE_WIDTH(STATE_WIDTH)
	) u_filter (
		.clk   (clk),
		.arst_n(arst_n),
		.start (filt_start),
		.err   (err[XW-1:0]),
		.coefs (coefs_q),
		.res   (filt_res)
	);

	always_comb begin
		err        = EW'(ref_q) - EW'(item_q.adc_sample);
		err_neg    = -err;
		in_win     = (err <= WIN_HI) && (err >= WIN_LO);
		filt_start = (st_q == T_EVAL) && in_win && item_q.digital_mode;
		if (err > LIM_HI) begin
			direct_duty = DUTY_LIM;
			direct_dir  = hpc_pkg::DIR_FWD;
		end else if (err < LIM_LO) begin
			direct_duty = DUTY_LIM;
			direct_dir  = hpc_pkg::DIR_REV;
		end else if (err[EW-1]) begin
			direct_duty = err_neg[DW-1:0];
			direct_dir  = hpc_pkg::DIR_REV;
		end else begin
			direct_duty = err[DW-1:0];
			direct_dir  = hpc_pkg::DIR_FWD;
		end
		out_free   = !out_valid_q || !out_stall;
		final_duty = item_q.motor_off ? ramp_q : duty_q;
		final_dir  = item_q.motor_off ? hpc_pkg::DIR_FWD : res_dir_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q                 <= RW'(hpc_pkg::REF_RESET);
			coefs_q.gain_in       <= hpc_pkg::COEF_WIDTH'(hpc_pkg::ONE_Q12);
			coefs_q.coef_cur_in   <= hpc_pkg::COEF_WIDTH'(hpc_pkg::ONE_Q12);
			coefs_q.coef_prev_in  <= '0;
			coefs_q.coef_prev_out <= '0;
			coefs_q.gain_out      <= hpc_pkg::COEF_WIDTH'(hpc_pkg::ONE_Q12);
		end else if (cfg_we) begin
			unique case (cfg_index)
				hpc_pkg::REG_REFERENCE:     ref_q                 <= cfg_data[RW-1:0];
				hpc_pkg::REG_GAIN_IN:       coefs_q.gain_in       <= cfg_data;
				hpc_pkg::REG_COEF_CUR_IN:   coefs_q.coef_cur_in   <= cfg_data;
				hpc_pkg::REG_COEF_PREV_IN:  coefs_q.coef_prev_in  <= cfg_data;
				hpc_pkg::REG_COEF_PREV_OUT: coefs_q.coef_prev_out <= cfg_data;
				hpc_pkg::REG_GAIN_OUT:      coefs_q.gain_out      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_IDLE;
			out_valid_q <= 1'b0;
			dir_q       <= hpc_pkg::DIR_NONE;
			ramp_q      <= DW'(hpc_pkg::RAMP_START);
		end else begin
			if (st_q == T_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				T_IDLE: begin
					if (in_valid) begin
						st_q <= T_EVAL;
					end
				end
				T_EVAL: begin
					st_q <= (in_win && item_q.digital_mode) ? T_FILT : T_OUT;
				end
				T_FILT: begin
					if (filt_res.done) begin
						st_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (out_free) begin
						st_q  <= T_IDLE;
						dir_q <= final_dir;
						if (item_q.motor_off && ramp_q != '0) begin
							ramp_q <= ramp_q - 1'b1;
						end
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == T_IDLE && in_valid) begin
			item_q <= in_item;
		end
		if (st_q == T_EVAL) begin
			res_fault_q <= !in_win;
			if (!in_win) begin
				duty_q    <= '0;
				res_dir_q <= dir_q;
			end else begin
				duty_q    <= direct_duty;
				res_dir_q <= direct_dir;
			end
		end
		if (st_q == T_FILT && filt_res.done) begin
			duty_q    <= filt_res.duty;
			res_dir_q <= filt_res.rev ? hpc_pkg::DIR_REV : hpc_pkg::DIR_FWD;
		end
		if (st_q == T_OUT && out_free) begin
			out_item_q.duty      <= final_duty;
			out_item_q.drive_fwd <= final_dir[0];
			out_item_q.drive_rev <= final_dir[1];
			out_item_q.fault     <= res_fault_q;
		end
	end

	assign in_stall  = (st_q != T_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
